// ----- design/whp_pkg.sv -----
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types for the WAV header parser: result status codes.
// ----------------------------------------------------------------------------
package whp_pkg;

	typedef enum logic [2:0] {
		ST_HEADER   = 3'd0,
		ST_HDR_DONE = 3'd1,
		ST_PAYLOAD  = 3'd2,
		ST_DONE     = 3'd3,
		ST_NOT_RIFF = 3'd4,
		ST_NOT_WAVE = 3'd5,
		ST_TRUNC    = 3'd6
	} status_t;

endpackage

// ----- design/whp_in_if.sv -----
// ----------------------------------------------------------------------------
// whp_in_if
// Byte stream channel into the parser: one file byte per request.
// ----------------------------------------------------------------------------
interface whp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	logic       stream_end;

	modport source (output valid, output data_byte, output file_start, output stream_end,
		input ready);
	modport sink (input valid, input data_byte, input file_start, input stream_end,
		output ready);
endinterface

// ----- design/whp_out_if.sv -----
// ----------------------------------------------------------------------------
// whp_out_if
// Result channel of the parser: status, payload byte and header fields.
// ----------------------------------------------------------------------------
interface whp_out_if import whp_pkg::*; ;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [7:0]  payload_byte;
	logic        payload_last;
	logic [15:0] format_tag;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] frame_bytes;
	logic [15:0] sample_bits;
	logic [31:0] payload_size;
	logic [32:0] total_size;

	modport source (output valid, output status, output payload_byte, output payload_last,
		output format_tag, output channel_count, output sample_rate,
		output byte_rate, output frame_bytes, output sample_bits,
		output payload_size, output total_size, input ready);
	modport sink (input valid, input status, input payload_byte, input payload_last,
		input format_tag, input channel_count, input sample_rate,
		input byte_rate, input frame_bytes, input sample_bits,
		input payload_size, input total_size, output ready);
endinterface

// ----- design/wav_header_parser.sv -----
// Each accepted byte's result request is registered, valid in the next cycle.
// Throughput: one byte per cycle; the result register takes a new result in
// the cycle the previous one is taken, so the only limit is the sink's ready.
// Reset (arst_n low): parser returns to the RIFF tag phase, all fields zero.
// file_start on a byte restarts the parser the same way before that byte.
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-serial RIFF/WAVE parser: checks tags, walks chunks, captures the fmt
// fields and passes the data chunk payload through, flagging its last byte.
// ----------------------------------------------------------------------------
module wav_header_parser import whp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	whp_in_if.sink      bytes,
	whp_out_if.source   results
);

	typedef enum logic [8:0] {
		PH_HDR      = 9'b000000001,
		PH_CHDR     = 9'b000000010,
		PH_FMT      = 9'b000000100,
		PH_SKIP     = 9'b000001000,
		PH_PAY      = 9'b000010000,
		PH_DONE     = 9'b000100000,
		PH_NOTRIFF  = 9'b001000000,
		PH_NOTWAVE  = 9'b010000000,
		PH_TRUNC    = 9'b100000000
	} phase_t;

	localparam logic [31:0] TAG_RIFF  = 32'h52494646;
	localparam logic [31:0] TAG_WAVE  = 32'h57415645;
	localparam logic [23:0] ID_FMT    = 24'h464D54;
	localparam logic [23:0] ID_DAT    = 24'h444154;
	localparam logic [4:0]  HDR_LAST  = 5'd11;
	localparam logic [4:0]  CHDR_LAST = 5'd7;
	localparam logic [4:0]  FMT_USED  = 5'd16;
	localparam logic [32:0] RIFF_HDR  = 33'd8;

	function automatic logic [7:0] fold_upper(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
	endfunction

	phase_t      phase_q, ph_c, ph_n;
	logic [4:0]  fc_q, fc_c, fc_n;
	logic [31:0] tag_q, tag_c, tag_n;
	logic [31:0] cl_q, cl_c, cl_n;
	logic [31:0] rl_q, rl_c, rl_n;
	logic [31:0] pl_q, pl_c, pl_n;
	logic        bad_q, bad_c, bad_n;
	logic        rk_q, rk_c, rk_n;
	logic        dk_q, dk_c, dk_n;
	logic [7:0]  fmt_q [16];
	logic [7:0]  fmt_c [16];
	logic [7:0]  fmt_n [16];

	status_t     st_n, status_q;
	logic [7:0]  pbyte_n, pbyte_q;
	logic        plast_n, plast_q;
	logic        special;
	logic        out_vld_q;
	logic        accept;
	logic [7:0]  b;
	logic        se;

	assign bytes.ready = !out_vld_q || results.ready;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;
	assign se          = bytes.stream_end;

	always_comb begin
		if (bytes.file_start) begin
			ph_c  = PH_HDR;
			fc_c  = '0;
			tag_c = '0;
			cl_c  = '0;
			rl_c  = '0;
			pl_c  = '0;
			bad_c = 1'b0;
			rk_c  = 1'b0;
			dk_c  = 1'b0;
			for (int i = 0; i < 16; i++) fmt_c[i] = '0;
		end else begin
			ph_c  = phase_q;
			fc_c  = fc_q;
			tag_c = tag_q;
			cl_c  = cl_q;
			rl_c  = rl_q;
			pl_c  = pl_q;
			bad_c = bad_q;
			rk_c  = rk_q;
			dk_c  = dk_q;
			for (int i = 0; i < 16; i++) fmt_c[i] = fmt_q[i];
		end
	end

	always_comb begin
		ph_n    = ph_c;
		fc_n    = fc_c;
		tag_n   = tag_c;
		cl_n    = cl_c;
		rl_n    = rl_c;
		pl_n    = pl_c;
		bad_n   = bad_c;
		rk_n    = rk_c;
		dk_n    = dk_c;
		for (int i = 0; i < 16; i++) fmt_n[i] = fmt_c[i];
		st_n    = ST_HEADER;
		pbyte_n = '0;
		plast_n = 1'b0;
		special = 1'b0;

		unique case (ph_c)
			PH_HDR: begin
				if (fc_c < 5'd4 || fc_c >= 5'd8) begin
					tag_n = {tag_c[23:0], fold_upper(b)};
				end else begin
					rl_n[{fc_c[1:0], 3'b000} +: 8] = b;
				end
				if (fc_c == 5'd3) bad_n = (tag_n != TAG_RIFF);
				if (fc_c == 5'd7) rk_n = 1'b1;
				fc_n = fc_c + 5'd1;
				if (fc_c == HDR_LAST) begin
					fc_n = '0;
					priority if (bad_n) ph_n = PH_NOTRIFF;
					else if (tag_n != TAG_WAVE) ph_n = PH_NOTWAVE;
					else ph_n = se ? PH_TRUNC : PH_CHDR;
				end else if (se) begin
					ph_n = PH_TRUNC;
				end
			end
			PH_CHDR: begin
				if (fc_c < 5'd4) begin
					tag_n = {tag_c[23:0], fold_upper(b)};
					if (fc_c == 5'd0) cl_n = '0;
				end else begin
					cl_n[{fc_c[1:0], 3'b000} +: 8] = b;
				end
				fc_n = fc_c + 5'd1;
				if (fc_c == CHDR_LAST) begin
					fc_n = '0;
					if (tag_n[31:8] == ID_DAT) begin
						pl_n = cl_n;
						dk_n = 1'b1;
						priority if (cl_n == '0) begin
							ph_n    = PH_DONE;
							st_n    = ST_HDR_DONE;
							special = 1'b1;
						end else if (se) begin
							ph_n = PH_TRUNC;
						end else begin
							ph_n    = PH_PAY;
							st_n    = ST_HDR_DONE;
							special = 1'b1;
						end
					end else begin
						if (cl_n == '0) ph_n = PH_CHDR;
						else if (tag_n[31:8] == ID_FMT) ph_n = PH_FMT;
						else ph_n = PH_SKIP;
						if (se) ph_n = PH_TRUNC;
					end
				end else if (se) begin
					ph_n = PH_TRUNC;
				end
			end
			PH_FMT: begin
				if (fc_c < FMT_USED) begin
					fmt_n[fc_c[3:0]] = b;
					fc_n = fc_c + 5'd1;
				end
				cl_n = cl_c - 32'd1;
				if (cl_n == '0) begin
					ph_n = PH_CHDR;
					fc_n = '0;
				end
				if (se) ph_n = PH_TRUNC;
			end
			PH_SKIP: begin
				cl_n = cl_c - 32'd1;
				if (cl_n == '0) begin
					ph_n = PH_CHDR;
					fc_n = '0;
				end
				if (se) ph_n = PH_TRUNC;
			end
			PH_PAY: begin
				pbyte_n = b;
				special = 1'b1;
				pl_n    = pl_c - 32'd1;
				priority if (pl_n == '0) begin
					plast_n = 1'b1;
					st_n    = ST_PAYLOAD;
					ph_n    = PH_DONE;
				end else if (se) begin
					st_n = ST_TRUNC;
					ph_n = PH_TRUNC;
				end else begin
					st_n = ST_PAYLOAD;
				end
			end
			default: begin
			end
		endcase

		if (!special) begin
			unique case (ph_n)
				PH_DONE:    st_n = ST_DONE;
				PH_NOTRIFF: st_n = ST_NOT_RIFF;
				PH_NOTWAVE: st_n = ST_NOT_WAVE;
				PH_TRUNC:   st_n = ST_TRUNC;
				PH_HDR, PH_CHDR, PH_FMT, PH_SKIP: st_n = ST_HEADER;
				default: begin
					st_n = ST_TRUNC;
					ph_n = PH_TRUNC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			fc_q    <= '0;
			tag_q   <= '0;
			cl_q    <= '0;
			rl_q    <= '0;
			pl_q    <= '0;
			bad_q   <= 1'b0;
			rk_q    <= 1'b0;
			dk_q    <= 1'b0;
			for (int i = 0; i < 16; i++) fmt_q[i] <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			fc_q    <= fc_n;
			tag_q   <= tag_n;
			cl_q    <= cl_n;
			rl_q    <= rl_n;
			pl_q    <= pl_n;
			bad_q   <= bad_n;
			rk_q    <= rk_n;
			dk_q    <= dk_n;
			for (int i = 0; i < 16; i++) fmt_q[i] <= fmt_n[i];
		end
	end

	// result register; header fields read straight from state, which only
	// moves when a new result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_n;
			pbyte_q  <= pbyte_n;
			plast_q  <= plast_n;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.status        = status_q;
	assign results.payload_byte  = pbyte_q;
	assign results.payload_last  = plast_q;
	assign results.format_tag    = {fmt_q[1], fmt_q[0]};
	assign results.channel_count = {fmt_q[3], fmt_q[2]};
	assign results.sample_rate   = {fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]};
	assign results.byte_rate     = {fmt_q[11], fmt_q[10], fmt_q[9], fmt_q[8]};
	assign results.frame_bytes   = {fmt_q[13], fmt_q[12]};
	assign results.sample_bits   = {fmt_q[15], fmt_q[14]};
	assign results.payload_size  = dk_q ? cl_q : '0;
	assign results.total_size    = rk_q ? ({1'b0, rl_q} + RIFF_HDR) : '0;

endmodule
